@@ src/hmm_pkg.sv @@
// Shared constants, types and helpers for the log-domain HMM forward block.
`timescale 1ns / 1ps
package hmm_pkg;
	localparam int NumStates  = 8;
	localparam int NumSymbols = 16;
	localparam int FracBits   = 8;
	localparam int ValW       = 20;
	localparam int CorrDepth  = 8 * 256;

	localparam logic signed [ValW-1:0] NegInf = {1'b1, {(ValW-1){1'b0}}};
	localparam logic signed [ValW-1:0] MaxFin = {1'b0, {(ValW-1){1'b1}}};
	localparam logic signed [ValW-1:0] MinFin = {1'b1, {(ValW-2){1'b0}}, 1'b1};

	localparam logic [1:0] OpLoadA  = 2'd0;
	localparam logic [1:0] OpLoadB  = 2'd1;
	localparam logic [1:0] OpLoadPi = 2'd2;
	localparam logic [1:0] OpObs    = 2'd3;

	typedef logic signed [ValW-1:0] val_t;

	function automatic val_t sat_add(input val_t a, input val_t b);
		logic signed [ValW:0] s;
		begin
			s = {a[ValW-1], a} + {b[ValW-1], b};
			if (a == NegInf || b == NegInf) sat_add = NegInf;
			else if (s > $signed({1'b0, MaxFin})) sat_add = MaxFin;
			else if (s < $signed({1'b1, MinFin})) sat_add = MinFin;
			else sat_add = s[ValW-1:0];
		end
	endfunction
endpackage

@@ src/hmm_lse.sv @@
// Log-sum-exp accumulate step: combinational difference, registered max and ROM correction.
`timescale 1ns / 1ps
module hmm_lse #(
	parameter int FRAC_BITS = hmm_pkg::FracBits
) (
	input  logic          clk,
	input  logic          en,
	input  hmm_pkg::val_t a,
	input  hmm_pkg::val_t b,
	output hmm_pkg::val_t y
);
	localparam int Lim = 8 << FRAC_BITS;
	localparam int DW  = $clog2(Lim);
	localparam real Step = 1.0 / (2.0 ** FRAC_BITS);

	logic [15:0] corr_rom [Lim];
	logic [15:0] corr_q;
	hmm_pkg::val_t m_s1;
	logic pass_s1;
	logic signed [hmm_pkg::ValW:0] diff;
	logic [hmm_pkg::ValW:0] d;

	always_comb begin
		diff = {a[hmm_pkg::ValW-1], a} - {b[hmm_pkg::ValW-1], b};
		d = diff[hmm_pkg::ValW] ? -diff : diff;
	end

	// correction table filled once from the analytic curve
	initial begin
		for (int k = 0; k < Lim; k++)
			corr_rom[k] = 16'($rtoi($floor((2.0 ** FRAC_BITS) *
				$ln(1.0 + $exp(-real'(k) * Step)) + 0.5)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s1 <= (a == hmm_pkg::NegInf) || (b == hmm_pkg::NegInf) || (d >= Lim);
			m_s1 <= (a == hmm_pkg::NegInf) ? b : (b == hmm_pkg::NegInf) ? a :
				(diff[hmm_pkg::ValW] ? b : a);
			corr_q <= (d < Lim) ? corr_rom[d[DW-1:0]] : 16'd0;
		end
	end

	assign y = pass_s1 ? m_s1 :
		hmm_pkg::sat_add(m_s1, hmm_pkg::val_t'({4'd0, corr_q}));
endmodule

@@ src/hmm_log_forward_step.sv @@
// Top level of the log-domain HMM forward recursion.
// Input channel (in_valid/in_ready) carries one word per table load or
// observation. op 0..2 write the transition, emission or initial tables in
// memories and give no result. op 3 gives one result word per active state
// on out_valid/out_ready, last set on the final one. One observation is
// handled at a time; in_ready stays low until it is done. For each state,
// an induction step reads, accumulates and folds in every term through the
// single shared log-sum-exp unit, then adds the emission and outputs the
// word; a start observation skips the accumulation. After the last state
// the new vector is copied back. Results leave through one output register;
// when the receiver stalls the sequencer holds. Reset (arst_n low) clears
// the sequencer and sets states_in_use to 8; table contents stay undefined
// until loaded. states_in_use is written by cfg_we/cfg_data; the user must
// write it only while idle, as the block does not enforce this.
`timescale 1ns / 1ps
module hmm_log_forward_step #(
	parameter int NUM_STATES  = hmm_pkg::NumStates,
	parameter int NUM_SYMBOLS = hmm_pkg::NumSymbols,
	parameter int FRAC_BITS   = hmm_pkg::FracBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [2:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic signed [19:0] log_value,
	input  logic [3:0]  symbol,
	input  logic        sequence_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  state_index,
	output logic signed [19:0] log_forward,
	output logic        last
);
	localparam int SW  = $clog2(NUM_STATES);
	localparam int YW  = $clog2(NUM_SYMBOLS);
	localparam int TAW = $clog2(NUM_STATES*NUM_STATES);
	localparam int EAW = $clog2(NUM_STATES*NUM_SYMBOLS);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StRead = 3'd1;
	localparam logic [2:0] StAcc  = 3'd2;
	localparam logic [2:0] StLse  = 3'd3;
	localparam logic [2:0] StEmit = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;
	localparam logic [2:0] StCopy = 3'd6;

	hmm_pkg::val_t trans_mem [NUM_STATES*NUM_STATES];
	hmm_pkg::val_t emis_mem  [NUM_STATES*NUM_SYMBOLS];
	hmm_pkg::val_t init_mem  [NUM_STATES];
	hmm_pkg::val_t fwd_mem   [NUM_STATES];
	hmm_pkg::val_t next_mem  [NUM_STATES];

	logic [2:0] state_q;
	logic [3:0] n_cfg_q;
	logic [SW-1:0] n_last_q, i_q, j_q;
	logic start_q, sym_ok_q;
	logic [YW-1:0] sym_q;
	hmm_pkg::val_t acc_q, a_rd_q, f_rd_q, b_rd_q, p_rd_q, nx_rd_q;
	hmm_pkg::val_t lse_y, term, emit_val;
	logic lse_en;
	logic [4:0] n_eff;
	logic cp_we_s1;
	logic [SW-1:0] cp_addr_s1;

	always_comb begin
		n_eff = (n_cfg_q == 4'd0) ? 5'd1 : {1'b0, n_cfg_q};
		if (32'(n_eff) > NUM_STATES) n_eff = 5'(NUM_STATES);
		if (n_eff > 5'd8) n_eff = 5'd8;
	end

	assign in_ready = (state_q == StIdle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) n_cfg_q <= 4'd8;
		else if (cfg_we) n_cfg_q <= cfg_data;
	end

	// table and vector memory writes
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (op == hmm_pkg::OpLoadA && 32'(row_index) < NUM_STATES &&
				32'(col_index) < NUM_STATES)
				trans_mem[TAW'(row_index[SW-1:0] * NUM_STATES + col_index[SW-1:0])] <=
					log_value;
			if (op == hmm_pkg::OpLoadB && 32'(row_index) < NUM_STATES &&
				32'(col_index) < NUM_SYMBOLS)
				emis_mem[EAW'(row_index[SW-1:0] * NUM_SYMBOLS + col_index[YW-1:0])] <=
					log_value;
			if (op == hmm_pkg::OpLoadPi && 32'(row_index) < NUM_STATES)
				init_mem[row_index[SW-1:0]] <= log_value;
		end
		if (state_q == StEmit) next_mem[i_q] <= emit_val;
		if (cp_we_s1) fwd_mem[cp_addr_s1] <= nx_rd_q;
	end

	// registered memory reads
	always_ff @(posedge clk) begin
		a_rd_q  <= trans_mem[TAW'(j_q * NUM_STATES + i_q)];
		f_rd_q  <= fwd_mem[j_q];
		b_rd_q  <= emis_mem[EAW'(i_q * NUM_SYMBOLS + sym_q)];
		p_rd_q  <= init_mem[i_q];
		nx_rd_q <= next_mem[j_q];
	end

	assign term = hmm_pkg::sat_add(f_rd_q, a_rd_q);
	assign lse_en = (state_q == StAcc);
	assign emit_val = hmm_pkg::sat_add(start_q ? p_rd_q : acc_q,
		sym_ok_q ? b_rd_q : hmm_pkg::NegInf);

	hmm_lse #(.FRAC_BITS(FRAC_BITS)) u_lse (
		.clk(clk), .en(lse_en), .a(acc_q), .b(term), .y(lse_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			cp_we_s1 <= 1'b0;
			cp_addr_s1 <= '0;
		end else begin
			cp_we_s1 <= (state_q == StCopy);
			cp_addr_s1 <= j_q;
			case (state_q)
				StIdle: begin
					if (in_valid && op == hmm_pkg::OpObs) begin
						start_q  <= sequence_start;
						sym_ok_q <= 32'(symbol) < NUM_SYMBOLS;
						sym_q    <= symbol[YW-1:0];
						n_last_q <= SW'(n_eff - 5'd1);
						i_q <= '0;
						j_q <= '0;
						acc_q <= hmm_pkg::NegInf;
						state_q <= StRead;
					end
				end
				StRead: state_q <= start_q ? StEmit : StAcc;
				StAcc: state_q <= StLse;
				StLse: begin
					acc_q <= lse_y;
					if (j_q == n_last_q) state_q <= StEmit;
					else begin
						j_q <= j_q + SW'(1);
						state_q <= StRead;
					end
				end
				StEmit: begin
					state_q <= StOut;
					out_valid <= 1'b1;
					state_index <= 3'(i_q);
					log_forward <= emit_val;
					last <= (i_q == n_last_q);
				end
				StOut: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (i_q == n_last_q) begin
							j_q <= '0;
							state_q <= StCopy;
						end else begin
							i_q <= i_q + SW'(1);
							j_q <= '0;
							acc_q <= hmm_pkg::NegInf;
							state_q <= StRead;
						end
					end
				end
				StCopy: begin
					// write back trails j_q through a register to line up with the registered next_mem read
					if (j_q == n_last_q) state_q <= StIdle;
					j_q <= j_q + SW'(1);
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == StOut) else $error("result word outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(log_forward))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("accepting while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != StIdle) |-> i_q <= n_last_q) else $error("state index overran");
endmodule
